// ----- hw/rtl/ffra_pkg.sv -----
// Shared types and constants of the first-fit region allocator.
`timescale 1ns / 1ps

package ffra_pkg;

    localparam int ADDR_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_USED_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE    = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_NO_REGION  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES = 1'd1;

    localparam logic [ADDR_W-1:0] POOL_BASE_RESET  = 32'd0;
    localparam logic [ADDR_W-1:0] POOL_BYTES_RESET = 32'd4194304;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_A,
        S_SCAN_B,
        S_FINISH
    } state_t;

endpackage

// ----- hw/rtl/ffra_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps

module ffra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/first_fit_region_allocator.sv -----
// First-fit region allocator: top level with the table sequencer.
//
//  channel | signals                                     | dir | handshake
//  --------+---------------------------------------------+-----+---------------
//  in      | func, request_bytes, target_address         | in  | in_valid/in_ready
//  out     | granted_address, status, legitimate         | out | out_valid/out_ready
//  cfg     | cfg_index, cfg_data                         | in  | cfg_we, no wait
//
// Each table is scanned one entry a cycle through the read port of its RAM: the free
// then the allocated table for an allocation, the allocated then the free table for a
// release, the allocated table alone for a check. Reset and every config write start a
// rebuild pass that rewrites both tables; no word is taken during it.
// A finished result sits in the output register; the next word is taken while it
// waits, and that word holds in S_FINISH until the register is free.
// PAGE_BYTES must be a power of two.
`timescale 1ns / 1ps

module first_fit_region_allocator
    import ffra_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int PAGE_BYTES    = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic [ADDR_W-1:0]    request_bytes,
    input  logic [ADDR_W-1:0]    target_address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    granted_address,
    output logic [STATUS_W-1:0]  status,
    output logic                 legitimate,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int EW = 2 * ADDR_W;
    localparam logic [IW-1:0]     LAST_IDX   = IW'(TABLE_ENTRIES - 1);
    localparam logic [ADDR_W:0]   MGMT_BYTES = (ADDR_W + 1)'(2 * PAGE_BYTES);
    localparam logic [ADDR_W:0]   PAGE_MASK  = (ADDR_W + 1)'(PAGE_BYTES - 1);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]   pool_base_reg, pool_bytes_reg;
    logic [FUNC_W-1:0]   op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W:0]     rounded_reg, rounded_next;
    logic [IW-1:0]       scan_idx_reg, scan_idx_next;
    logic [IW-1:0]       data_idx_reg, data_idx_next;
    logic                pend_reg, pend_next;
    logic [IW-1:0]       cap_idx_reg, cap_idx_next;
    logic [ADDR_W-1:0]   cap_base_reg, cap_base_next;
    logic [ADDR_W-1:0]   cap_len_reg, cap_len_next;
    logic [ADDR_W-1:0]   res_granted_reg, res_granted_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_legit_reg, res_legit_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_granted_reg, out_granted_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_legit_reg, out_legit_next;

    logic          used_we, spare_we;
    logic [IW-1:0] used_waddr, spare_waddr;
    logic [EW-1:0] used_wdata, spare_wdata;
    logic [EW-1:0] used_rdata, spare_rdata;

    logic [ADDR_W-1:0] used_base_rd, used_len_rd, spare_base_rd, spare_len_rd;
    logic [ADDR_W-1:0] usable_bytes;
    logic [ADDR_W:0]   pool_end, mgmt_end, want_rounded, used_end;
    logic              accept, bad_size, outside, in_mgmt, immediate;
    logic              hit_a, hit_b, scan_end_a, scan_end_b, out_free;

    assign used_base_rd  = used_rdata[EW-1:ADDR_W];
    assign used_len_rd   = used_rdata[ADDR_W-1:0];
    assign spare_base_rd = spare_rdata[EW-1:ADDR_W];
    assign spare_len_rd  = spare_rdata[ADDR_W-1:0];

    assign usable_bytes = ({1'b0, pool_bytes_reg} > MGMT_BYTES)
                        ? pool_bytes_reg - MGMT_BYTES[ADDR_W-1:0] : '0;
    assign pool_end     = {1'b0, pool_base_reg} + {1'b0, pool_bytes_reg};
    assign mgmt_end     = {1'b0, pool_base_reg} + MGMT_BYTES;
    assign want_rounded = ({1'b0, request_bytes} + PAGE_MASK) & ~PAGE_MASK;
    assign used_end     = {1'b0, used_base_rd} + {1'b0, used_len_rd};

    assign accept    = in_valid && in_ready;
    assign bad_size  = (request_bytes == '0) || (request_bytes > usable_bytes);
    assign outside   = (target_address < pool_base_reg) || ({1'b0, target_address} >= pool_end);
    assign in_mgmt   = (target_address >= pool_base_reg) && ({1'b0, target_address} < mgmt_end);
    assign immediate = ((func == FUNC_ALLOC) && bad_size)
                    || ((func == FUNC_RELEASE) && outside)
                    || ((func == FUNC_CHECK) && in_mgmt)
                    || ((func != FUNC_ALLOC) && (func != FUNC_RELEASE) && (func != FUNC_CHECK));
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        case (op_reg)
            FUNC_ALLOC:   hit_a = {1'b0, spare_len_rd} >= rounded_reg;
            FUNC_RELEASE: hit_a = (used_base_rd == addr_reg) && (used_len_rd != '0);
            FUNC_CHECK:   hit_a = (addr_reg >= used_base_rd) && ({1'b0, addr_reg} < used_end);
            default:      hit_a = 1'b0;
        endcase
        case (op_reg)
            FUNC_ALLOC:   hit_b = (used_len_rd == '0);
            FUNC_RELEASE: hit_b = (spare_len_rd == '0);
            default:      hit_b = 1'b0;
        endcase
    end

    assign scan_end_a = pend_reg && (hit_a || (data_idx_reg == LAST_IDX));
    assign scan_end_b = pend_reg && (hit_b || (data_idx_reg == LAST_IDX));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = immediate ? S_FINISH : S_SCAN_A;
                end
            end
            S_SCAN_A:
            begin
                if (scan_end_a)
                begin
                    state_next = (hit_a && (op_reg != FUNC_CHECK)) ? S_SCAN_B : S_FINISH;
                end
            end
            S_SCAN_B:
            begin
                if (scan_end_b)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
        if (cfg_we)
        begin
            state_next = S_CLEAR;
        end
    end

    // RAM ports and handshake
    always_comb
    begin
        in_ready    = 1'b0;
        used_we     = 1'b0;
        spare_we    = 1'b0;
        used_waddr  = scan_idx_reg;
        spare_waddr = scan_idx_reg;
        used_wdata  = '0;
        spare_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                used_we  = 1'b1;
                spare_we = 1'b1;
                if (scan_idx_reg == '0)
                begin
                    used_wdata  = {pool_base_reg, MGMT_BYTES[ADDR_W-1:0]};
                    spare_wdata = {mgmt_end[ADDR_W-1:0], usable_bytes};
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_SCAN_B:
            begin
                if (pend_reg && hit_b)
                begin
                    used_we  = 1'b1;
                    spare_we = 1'b1;
                    if (op_reg == FUNC_ALLOC)
                    begin
                        used_waddr  = data_idx_reg;
                        used_wdata  = {cap_base_reg, rounded_reg[ADDR_W-1:0]};
                        spare_waddr = cap_idx_reg;
                        spare_wdata = {cap_base_reg + rounded_reg[ADDR_W-1:0],
                                       cap_len_reg - rounded_reg[ADDR_W-1:0]};
                    end
                    else
                    begin
                        used_waddr  = cap_idx_reg;
                        used_wdata  = {addr_reg, {ADDR_W{1'b0}}};
                        spare_waddr = data_idx_reg;
                        spare_wdata = {addr_reg, cap_len_reg};
                    end
                end
            end
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        op_next          = op_reg;
        addr_next        = addr_reg;
        rounded_next     = rounded_reg;
        scan_idx_next    = scan_idx_reg;
        data_idx_next    = data_idx_reg;
        pend_next        = pend_reg;
        cap_idx_next     = cap_idx_reg;
        cap_base_next    = cap_base_reg;
        cap_len_next     = cap_len_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        res_legit_next   = res_legit_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_granted_next = out_granted_reg;
        out_status_next  = out_status_reg;
        out_legit_next   = out_legit_reg;
        case (state_reg)
            S_CLEAR:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next          = func;
                    addr_next        = target_address;
                    rounded_next     = want_rounded;
                    scan_idx_next    = '0;
                    pend_next        = 1'b0;
                    res_granted_next = '0;
                    res_status_next  = STATUS_OK;
                    res_legit_next   = 1'b0;
                    if ((func == FUNC_ALLOC) && bad_size)
                    begin
                        res_status_next = STATUS_BAD_SIZE;
                    end
                    else if ((func == FUNC_RELEASE) && outside)
                    begin
                        res_status_next = STATUS_OUTSIDE;
                    end
                    else if ((func == FUNC_CHECK) && in_mgmt)
                    begin
                        res_legit_next = 1'b1;
                    end
                end
            end
            S_SCAN_A:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                data_idx_next = scan_idx_reg;
                pend_next     = 1'b1;
                if (scan_end_a)
                begin
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    if (hit_a)
                    begin
                        cap_idx_next  = data_idx_reg;
                        cap_base_next = spare_base_rd;
                        cap_len_next  = (op_reg == FUNC_ALLOC) ? spare_len_rd : used_len_rd;
                        if (op_reg == FUNC_CHECK)
                        begin
                            res_legit_next = 1'b1;
                        end
                    end
                    else if (op_reg == FUNC_ALLOC)
                    begin
                        res_status_next = STATUS_NO_FREE;
                    end
                    else if (op_reg == FUNC_RELEASE)
                    begin
                        res_status_next = STATUS_NO_REGION;
                    end
                end
            end
            S_SCAN_B:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                data_idx_next = scan_idx_reg;
                pend_next     = 1'b1;
                if (scan_end_b)
                begin
                    pend_next = 1'b0;
                    if (hit_b)
                    begin
                        if (op_reg == FUNC_ALLOC)
                        begin
                            res_granted_next = cap_base_reg;
                        end
                    end
                    else
                    begin
                        res_status_next = (op_reg == FUNC_ALLOC) ? STATUS_USED_FULL
                                                                 : STATUS_NO_FREE;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_status_next  = res_status_reg;
                    out_legit_next   = res_legit_reg;
                end
            end
            default: ;
        endcase
        if (cfg_we)
        begin
            scan_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            pool_base_reg  <= POOL_BASE_RESET;
            pool_bytes_reg <= POOL_BYTES_RESET;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POOL_BASE:  pool_base_reg  <= cfg_data;
                    REG_POOL_BYTES: pool_bytes_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        addr_reg        <= addr_next;
        rounded_reg     <= rounded_next;
        data_idx_reg    <= data_idx_next;
        cap_idx_reg     <= cap_idx_next;
        cap_base_reg    <= cap_base_next;
        cap_len_reg     <= cap_len_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        res_legit_reg   <= res_legit_next;
        out_granted_reg <= out_granted_next;
        out_status_reg  <= out_status_next;
        out_legit_reg   <= out_legit_next;
    end

    // allocated table: {base, length}
    ffra_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (scan_idx_reg),
        .rdata (used_rdata)
    );

    // free table: {base, length}
    ffra_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_spare_ram (
        .clk   (clk),
        .we    (spare_we),
        .waddr (spare_waddr),
        .wdata (spare_wdata),
        .raddr (scan_idx_reg),
        .rdata (spare_rdata)
    );

    assign out_valid       = out_valid_reg;
    assign granted_address = out_granted_reg;
    assign status          = out_status_reg;
    assign legitimate      = out_legit_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the first-fit region allocator: directed and random requests.
`timescale 1ns / 1ps

module tb_top;
    import ffra_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int PAGE        = 4096;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 2 * ENTRIES + 8;
    localparam int PHASES      = 8;
    localparam int PLAN_ROWS   = 25;

    localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;
    localparam logic [ADDR_W:0]   MGMT_WIDE  = 33'(2 * PAGE);
    localparam logic [ADDR_W-1:0] MGMT_BYTES = 32'(2 * PAGE);

    typedef struct packed {
        logic [ADDR_W-1:0]   granted;
        logic [STATUS_W-1:0] status;
        logic                legit;
    } outcome_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [ADDR_W-1:0] want;
        logic [ADDR_W-1:0] addr;
        logic              known;
        outcome_t          result;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func;
    logic [ADDR_W-1:0]    request_bytes;
    logic [ADDR_W-1:0]    target_address;
    logic                 out_valid;
    logic                 out_ready;
    logic [ADDR_W-1:0]    granted_address;
    logic [STATUS_W-1:0]  status;
    logic                 legitimate;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    first_fit_region_allocator #(
        .TABLE_ENTRIES(ENTRIES),
        .PAGE_BYTES   (PAGE)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .request_bytes  (request_bytes),
        .target_address (target_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .granted_address(granted_address),
        .status         (status),
        .legitimate     (legitimate),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // shadow copy of the pool and both region tables
    logic [ADDR_W-1:0] pool_base;
    logic [ADDR_W-1:0] pool_bytes;
    logic [ADDR_W-1:0] used_base    [ENTRIES];
    logic [ADDR_W-1:0] used_length  [ENTRIES];
    logic [ADDR_W-1:0] spare_base   [ENTRIES];
    logic [ADDR_W-1:0] spare_length [ENTRIES];

    outcome_t          pending_outcomes [$];
    logic [ADDR_W-1:0] live_bases [$];
    int                mismatches  = 0;
    int                words_seen  = 0;
    int                cycle_count = 0;
    bit                send_calm   = 0;

    logic [ADDR_W-1:0] phase_base  [PHASES] = '{32'h1000_0000, 32'h0000_0000, 32'hFFFF_F000,
                                               32'h0000_0000, 32'h8000_0000, 32'h0000_1000,
                                               32'hFFFF_FFFF, 32'h4000_0000};
    logic [ADDR_W-1:0] phase_bytes [PHASES] = '{32'h0010_0000, 32'h0040_0000, 32'hFFFF_FFFF,
                                               32'h0000_0000, 32'h0000_2000, 32'h0000_5000,
                                               32'h0001_0000, 32'h0004_0000};
    int                phase_words [PHASES] = '{200, 150, 150, 60, 60, 100, 120, 60};

    plan_row_t directed_plan [PLAN_ROWS] = '{
        '{FUNC_CHECK,   32'h0,        32'h0,        1'b1, '{32'h0,    STATUS_OK,        1'b1}},
        '{FUNC_CHECK,   32'h0,        32'h1FFF,     1'b1, '{32'h0,    STATUS_OK,        1'b1}},
        '{FUNC_CHECK,   32'h0,        32'h2000,     1'b1, '{32'h0,    STATUS_OK,        1'b0}},
        '{FUNC_ALLOC,   32'h0,        32'h0,        1'b1, '{32'h0,    STATUS_BAD_SIZE,  1'b0}},
        '{FUNC_ALLOC,   32'h1,        32'h0,        1'b1, '{32'h2000, STATUS_OK,        1'b0}},
        '{FUNC_ALLOC,   32'h1000,     32'h0,        1'b1, '{32'h3000, STATUS_OK,        1'b0}},
        '{FUNC_ALLOC,   32'h1001,     32'h0,        1'b1, '{32'h4000, STATUS_OK,        1'b0}},
        '{FUNC_ALLOC,   32'hFFFFFFFF, 32'h0,        1'b1, '{32'h0,    STATUS_BAD_SIZE,  1'b0}},
        '{FUNC_ALLOC,   32'h3FE001,   32'h0,        1'b1, '{32'h0,    STATUS_BAD_SIZE,  1'b0}},
        '{FUNC_ALLOC,   32'h3FE000,   32'h0,        1'b1, '{32'h0,    STATUS_NO_FREE,   1'b0}},
        '{FUNC_CHECK,   32'h0,        32'h2000,     1'b1, '{32'h0,    STATUS_OK,        1'b1}},
        '{FUNC_CHECK,   32'h0,        32'h5FFF,     1'b1, '{32'h0,    STATUS_OK,        1'b1}},
        '{FUNC_CHECK,   32'h0,        32'h6000,     1'b1, '{32'h0,    STATUS_OK,        1'b0}},
        '{FUNC_CHECK,   32'h0,        32'hFFFFFFFF, 1'b1, '{32'h0,    STATUS_OK,        1'b0}},
        '{FUNC_RELEASE, 32'h0,        32'h400000,   1'b1, '{32'h0,    STATUS_OUTSIDE,   1'b0}},
        '{FUNC_RELEASE, 32'h0,        32'hFFFFFFFF, 1'b1, '{32'h0,    STATUS_OUTSIDE,   1'b0}},
        '{FUNC_RELEASE, 32'h0,        32'h2001,     1'b1, '{32'h0,    STATUS_NO_REGION, 1'b0}},
        '{FUNC_RELEASE, 32'h0,        32'h3000,     1'b1, '{32'h0,    STATUS_OK,        1'b0}},
        '{FUNC_CHECK,   32'h0,        32'h3000,     1'b1, '{32'h0,    STATUS_OK,        1'b0}},
        '{FUNC_RELEASE, 32'h0,        32'h3000,     1'b1, '{32'h0,    STATUS_NO_REGION, 1'b0}},
        '{FUNC_RELEASE, 32'h0,        32'h0,        1'b1, '{32'h0,    STATUS_OK,        1'b0}},
        '{FUNC_CHECK,   32'h0,        32'h0,        1'b1, '{32'h0,    STATUS_OK,        1'b1}},
        '{FUNC_UNDEF,   32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{32'h0,    STATUS_OK,        1'b0}},
        '{FUNC_ALLOC,   32'h1000,     32'hFFFFFFFF, 1'b0, '{32'h0,    STATUS_OK,        1'b0}},
        '{FUNC_ALLOC,   32'h3F9000,   32'h0,        1'b0, '{32'h0,    STATUS_OK,        1'b0}}
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int draw_pause(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = ~calm;
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [ADDR_W-1:0] usable_bytes();
        return (pool_bytes > MGMT_BYTES) ? pool_bytes - MGMT_BYTES : '0;
    endfunction

    function automatic void rebuild_tables();
        for (int k = 0; k < ENTRIES; k++)
        begin
            used_base[k]    = '0;
            used_length[k]  = '0;
            spare_base[k]   = '0;
            spare_length[k] = '0;
        end
        used_base[0]    = pool_base;
        used_length[0]  = MGMT_BYTES;
        spare_base[0]   = pool_base + MGMT_BYTES;
        spare_length[0] = usable_bytes();
    endfunction

    function automatic outcome_t forecast_outcome(input logic [FUNC_W-1:0] op,
                                                  input logic [ADDR_W-1:0] want,
                                                  input logic [ADDR_W-1:0] addr);
        outcome_t        o;
        logic [ADDR_W:0] rounded;
        logic [ADDR_W:0] pool_end;
        logic [ADDR_W:0] mgmt_end;
        int              f;
        int              u;
        o        = '0;
        f        = -1;
        u        = -1;
        pool_end = {1'b0, pool_base} + {1'b0, pool_bytes};
        mgmt_end = {1'b0, pool_base} + MGMT_WIDE;
        rounded  = ({1'b0, want} + 33'(PAGE - 1)) & ~33'(PAGE - 1);
        case (op)
            FUNC_ALLOC:
            begin
                if (want == '0 || want > usable_bytes())
                    o.status = STATUS_BAD_SIZE;
                else
                begin
                    for (int k = 0; k < ENTRIES; k++)
                    begin
                        if (f < 0 && {1'b0, spare_length[k]} >= rounded)
                            f = k;
                        if (u < 0 && used_length[k] == '0)
                            u = k;
                    end
                    if (f < 0)
                        o.status = STATUS_NO_FREE;
                    else if (u < 0)
                        o.status = STATUS_USED_FULL;
                    else
                    begin
                        o.granted       = spare_base[f];
                        used_base[u]    = spare_base[f];
                        used_length[u]  = rounded[ADDR_W-1:0];
                        spare_length[f] = spare_length[f] - rounded[ADDR_W-1:0];
                        spare_base[f]   = spare_base[f] + rounded[ADDR_W-1:0];
                    end
                end
            end
            FUNC_RELEASE:
            begin
                if (addr < pool_base || {1'b0, addr} >= pool_end)
                    o.status = STATUS_OUTSIDE;
                else
                begin
                    for (int k = 0; k < ENTRIES; k++)
                    begin
                        if (u < 0 && used_base[k] == addr && used_length[k] != '0)
                            u = k;
                        if (f < 0 && spare_length[k] == '0)
                            f = k;
                    end
                    if (u < 0)
                        o.status = STATUS_NO_REGION;
                    else if (f < 0)
                        o.status = STATUS_NO_FREE;
                    else
                    begin
                        spare_base[f]   = addr;
                        spare_length[f] = used_length[u];
                        used_length[u]  = '0;
                    end
                end
            end
            FUNC_CHECK:
            begin
                if (addr >= pool_base && {1'b0, addr} < mgmt_end)
                    o.legit = 1'b1;
                for (int k = 0; k < ENTRIES; k++)
                    if (addr >= used_base[k] &&
                        {1'b0, addr} < {1'b0, used_base[k]} + {1'b0, used_length[k]})
                        o.legit = 1'b1;
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_POOL_BASE)
            pool_base = val;
        else
            pool_bytes = val;
        rebuild_tables();
        repeat (ENTRIES + 8) @(negedge clk);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [FUNC_W-1:0] op, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] addr, input bit known,
                             input outcome_t typed);
        outcome_t o;
        int       pause;
        int       hit;
        pause = draw_pause(send_calm);
        hit   = -1;
        if (pause > 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        func           <= op;
        request_bytes  <= want;
        target_address <= addr;
        in_valid       <= 1'b1;
        do @(posedge clk); while (!in_ready);
        o = forecast_outcome(op, want, addr);
        if (op == FUNC_ALLOC && o.status == STATUS_OK)
            live_bases.push_back(o.granted);
        if (op == FUNC_RELEASE && o.status == STATUS_OK)
        begin
            foreach (live_bases[k])
                if (hit < 0 && live_bases[k] == addr)
                    hit = k;
            if (hit >= 0)
                live_bases.delete(hit);
        end
        pending_outcomes.push_back(known ? typed : o);
        @(negedge clk);
    endtask

    task automatic pick_random_word(output logic [FUNC_W-1:0] op, output logic [ADDR_W-1:0] want,
                                    output logic [ADDR_W-1:0] addr);
        int r;
        int s;
        r    = $urandom_range(0, 99);
        s    = $urandom_range(0, 19);
        want = $urandom;
        addr = $urandom;
        if (r < 42)
        begin
            op = FUNC_ALLOC;
            if (s == 0)
                want = '0;
            else if (s == 1)
                want = $urandom;
            else if (s == 2)
                want = usable_bytes();
            else if (s == 3)
                want = usable_bytes() + 1;
            else if (s < 7)
                want = PAGE * $urandom_range(1, 4);
            else
                want = $urandom_range(1, 4 * PAGE);
        end
        else if (r < 67)
        begin
            op = FUNC_RELEASE;
            if (s < 15 && live_bases.size() > 0)
                addr = live_bases[$urandom_range(0, live_bases.size() - 1)];
            else if (s < 17)
                addr = pool_base;
            else if (s < 19)
                addr = pool_base + PAGE * $urandom_range(0, 63);
        end
        else if (r < 95)
        begin
            op = FUNC_CHECK;
            if (s < 12 && live_bases.size() > 0)
                addr = live_bases[$urandom_range(0, live_bases.size() - 1)]
                       + $urandom_range(0, 3 * PAGE) - 1;
            else if (s < 16)
                addr = pool_base + $urandom_range(0, 3 * PAGE) - 1;
        end
        else
            op = FUNC_UNDEF;
    endtask

    initial
    begin
        logic [FUNC_W-1:0] op;
        logic [ADDR_W-1:0] want;
        logic [ADDR_W-1:0] addr;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = FUNC_ALLOC;
        request_bytes  = '0;
        target_address = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_POOL_BASE;
        cfg_data       = '0;
        pool_base      = POOL_BASE_RESET;
        pool_bytes     = POOL_BYTES_RESET;
        rebuild_tables();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
            send_word(directed_plan[i].op, directed_plan[i].want, directed_plan[i].addr,
                      directed_plan[i].known, directed_plan[i].result);

        for (int p = 0; p < PHASES; p++)
        begin
            in_valid <= 1'b0;
            while (pending_outcomes.size() != 0) @(negedge clk);
            repeat (4) @(negedge clk);
            write_register(REG_POOL_BASE, phase_base[p]);
            write_register(REG_POOL_BYTES, phase_bytes[p]);
            live_bases.delete();
            for (int i = 0; i < phase_words[p]; i++)
            begin
                pick_random_word(op, want, addr);
                send_word(op, want, addr, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        bit       calm;
        int       pause;
        outcome_t exp_o;
        out_ready = 1'b0;
        calm      = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            pause = draw_pause(calm);
            // one long hold-off so the block backs up into its input
            if (words_seen == HOLD_AT)
                pause = HOLD_CYCLES;
            if (pause > 0)
            begin
                out_ready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected word: granted %h status %0d legitimate %b",
                         $time, granted_address, status, legitimate);
                mismatches++;
            end
            else
            begin
                exp_o = pending_outcomes.pop_front();
                if (granted_address !== exp_o.granted)
                begin
                    $display("%0t: granted_address expected %h actual %h",
                             $time, exp_o.granted, granted_address);
                    mismatches++;
                end
                if (status !== exp_o.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_o.status, status);
                    mismatches++;
                end
                if (legitimate !== exp_o.legit)
                begin
                    $display("%0t: legitimate expected %b actual %b",
                             $time, exp_o.legit, legitimate);
                    mismatches++;
                end
            end
            words_seen++;
            @(negedge clk);
        end
    end

endmodule

// ----- sim.f -----
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_ram.sv
hw/rtl/first_fit_region_allocator.sv
tb/sv/tb_top.sv
